// ===== rtl/rvdec_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the RV32IM instruction decoder.
// No dependencies; used by the decoder top level and its checker.

package rvdec_pkg;

   // Major opcodes, bits 6..0 of the instruction word
   localparam logic [6:0] OPC_MASK   = 7'h7F;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   localparam logic [6:0] F7_MEXT = 7'h01;
   localparam logic [6:0] F7_ALT  = 7'h20;

   localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

   // Mnemonic codes
   localparam logic [5:0] MN_LUI      = 6'd0;
   localparam logic [5:0] MN_AUIPC    = 6'd1;
   localparam logic [5:0] MN_JAL      = 6'd2;
   localparam logic [5:0] MN_JALR     = 6'd3;
   localparam logic [5:0] MN_BEQ      = 6'd4;
   localparam logic [5:0] MN_BNE      = 6'd5;
   localparam logic [5:0] MN_BLT      = 6'd6;
   localparam logic [5:0] MN_BGE      = 6'd7;
   localparam logic [5:0] MN_BLTU     = 6'd8;
   localparam logic [5:0] MN_BGEU     = 6'd9;
   localparam logic [5:0] MN_LB       = 6'd10;
   localparam logic [5:0] MN_LH       = 6'd11;
   localparam logic [5:0] MN_LW       = 6'd12;
   localparam logic [5:0] MN_LBU      = 6'd13;
   localparam logic [5:0] MN_LHU      = 6'd14;
   localparam logic [5:0] MN_SB       = 6'd15;
   localparam logic [5:0] MN_SH       = 6'd16;
   localparam logic [5:0] MN_SW       = 6'd17;
   localparam logic [5:0] MN_ADDI     = 6'd18;
   localparam logic [5:0] MN_SLTI     = 6'd19;
   localparam logic [5:0] MN_SLTIU    = 6'd20;
   localparam logic [5:0] MN_XORI     = 6'd21;
   localparam logic [5:0] MN_ORI      = 6'd22;
   localparam logic [5:0] MN_ANDI     = 6'd23;
   localparam logic [5:0] MN_SLLI     = 6'd24;
   localparam logic [5:0] MN_SRLI     = 6'd25;
   localparam logic [5:0] MN_SRAI     = 6'd26;
   localparam logic [5:0] MN_ADD      = 6'd27;
   localparam logic [5:0] MN_SUB      = 6'd28;
   localparam logic [5:0] MN_SLL      = 6'd29;
   localparam logic [5:0] MN_SLT      = 6'd30;
   localparam logic [5:0] MN_SLTU     = 6'd31;
   localparam logic [5:0] MN_XOR      = 6'd32;
   localparam logic [5:0] MN_SRL      = 6'd33;
   localparam logic [5:0] MN_SRA      = 6'd34;
   localparam logic [5:0] MN_OR       = 6'd35;
   localparam logic [5:0] MN_AND      = 6'd36;
   localparam logic [5:0] MN_MUL      = 6'd37;
   localparam logic [5:0] MN_MULH     = 6'd38;
   localparam logic [5:0] MN_MULHSU   = 6'd39;
   localparam logic [5:0] MN_MULHU    = 6'd40;
   localparam logic [5:0] MN_DIV      = 6'd41;
   localparam logic [5:0] MN_DIVU     = 6'd42;
   localparam logic [5:0] MN_REM      = 6'd43;
   localparam logic [5:0] MN_REMU     = 6'd44;
   localparam logic [5:0] MN_ECALL    = 6'd45;
   localparam logic [5:0] MN_BAD_BR   = 6'd46;
   localparam logic [5:0] MN_BAD_LD   = 6'd47;
   localparam logic [5:0] MN_BAD_ST   = 6'd48;
   localparam logic [5:0] MN_BAD_SYS  = 6'd49;
   localparam logic [5:0] MN_BAD_OPC  = 6'd50;

   typedef struct packed {
      logic [31:0] instr_address;
      logic [31:0] instruction_word;
   } req_type;

   typedef struct packed {
      logic [5:0]  mnemonic_code;
      logic [4:0]  dest_reg;
      logic [4:0]  src1_reg;
      logic [4:0]  src2_reg;
      logic [31:0] operand_value;
   } rsp_type;

endpackage

// ===== rtl/rv32im_instruction_decoder_unit.sv =====
`timescale 1ns / 1ps
// RV32IM instruction decoder: registered input, one pass of decode logic,
// registered result. Depends on rvdec_pkg for payload types and codes.
//
//  channel   ports                          direction  handshake
//  request   start, busy, req_payload       in         start && !busy
//  response  rsp_strobe, rsp_payload        out        rsp_strobe, one cycle
//
// One transaction is accepted per cycle while busy is low; each result passes
// through the input register, then the result register, after acceptance.
// The rate is set by the single decode pass plus one 32-bit target adder.
// busy is high during reset and clears once a clock edge sees reset low; low otherwise.
// The receiver cannot stall, so results are never held back.

module rv32im_instruction_decoder_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  rvdec_pkg::req_type  req_payload,
   output logic                rsp_strobe,
   output rvdec_pkg::rsp_type  rsp_payload
);

   logic               busy_ff;
   logic               req_valid_ff;
   rvdec_pkg::req_type req_ff;
   logic               rsp_valid_ff;
   rvdec_pkg::rsp_type rsp_ff;
   rvdec_pkg::rsp_type rsp_in;

   logic [31:0] word;
   logic [6:0]  opc;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_b;
   logic [31:0] imm_j;
   logic [31:0] target;

   assign busy = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         req_valid_ff <= start && !busy_ff;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_payload;
      rsp_ff <= rsp_in;
   end

   assign word = req_ff.instruction_word;
   assign opc  = word[6:0] & rvdec_pkg::OPC_MASK;
   assign f3   = word[14:12];
   assign f7   = word[31:25];

   assign imm_i = {{20{word[31]}}, word[31:20]};
   assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
   assign imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
   assign imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};

   // One adder serves both jal and branch targets
   assign target = req_ff.instr_address + ((opc == rvdec_pkg::OPC_JAL) ? imm_j : imm_b);

   always_comb begin
      rsp_in.dest_reg      = word[11:7];
      rsp_in.src1_reg      = word[19:15];
      rsp_in.src2_reg      = word[24:20];
      rsp_in.mnemonic_code = rvdec_pkg::MN_BAD_OPC;
      rsp_in.operand_value = 32'd0;
      case (opc)
         rvdec_pkg::OPC_LUI: begin
            rsp_in.mnemonic_code = rvdec_pkg::MN_LUI;
            rsp_in.operand_value = {12'd0, word[31:12]};
         end
         rvdec_pkg::OPC_AUIPC: begin
            rsp_in.mnemonic_code = rvdec_pkg::MN_AUIPC;
            rsp_in.operand_value = {12'd0, word[31:12]};
         end
         rvdec_pkg::OPC_JAL: begin
            rsp_in.mnemonic_code = rvdec_pkg::MN_JAL;
            rsp_in.operand_value = target;
         end
         rvdec_pkg::OPC_JALR: begin
            rsp_in.mnemonic_code = rvdec_pkg::MN_JALR;
            rsp_in.operand_value = imm_i;
         end
         rvdec_pkg::OPC_BRANCH: begin
            rsp_in.operand_value = target;
            case (f3)
               3'd0:    rsp_in.mnemonic_code = rvdec_pkg::MN_BEQ;
               3'd1:    rsp_in.mnemonic_code = rvdec_pkg::MN_BNE;
               3'd4:    rsp_in.mnemonic_code = rvdec_pkg::MN_BLT;
               3'd5:    rsp_in.mnemonic_code = rvdec_pkg::MN_BGE;
               3'd6:    rsp_in.mnemonic_code = rvdec_pkg::MN_BLTU;
               3'd7:    rsp_in.mnemonic_code = rvdec_pkg::MN_BGEU;
               default: begin
                  rsp_in.mnemonic_code = rvdec_pkg::MN_BAD_BR;
                  rsp_in.operand_value = 32'd0;
               end
            endcase
         end
         rvdec_pkg::OPC_LOAD: begin
            rsp_in.operand_value = imm_i;
            case (f3)
               3'd0:    rsp_in.mnemonic_code = rvdec_pkg::MN_LB;
               3'd1:    rsp_in.mnemonic_code = rvdec_pkg::MN_LH;
               3'd2:    rsp_in.mnemonic_code = rvdec_pkg::MN_LW;
               3'd4:    rsp_in.mnemonic_code = rvdec_pkg::MN_LBU;
               3'd5:    rsp_in.mnemonic_code = rvdec_pkg::MN_LHU;
               default: begin
                  rsp_in.mnemonic_code = rvdec_pkg::MN_BAD_LD;
                  rsp_in.operand_value = 32'd0;
               end
            endcase
         end
         rvdec_pkg::OPC_STORE: begin
            rsp_in.operand_value = imm_s;
            case (f3)
               3'd0:    rsp_in.mnemonic_code = rvdec_pkg::MN_SB;
               3'd1:    rsp_in.mnemonic_code = rvdec_pkg::MN_SH;
               3'd2:    rsp_in.mnemonic_code = rvdec_pkg::MN_SW;
               default: begin
                  rsp_in.mnemonic_code = rvdec_pkg::MN_BAD_ST;
                  rsp_in.operand_value = 32'd0;
               end
            endcase
         end
         rvdec_pkg::OPC_OP_IMM: begin
            rsp_in.operand_value = imm_i;
            case (f3)
               3'd0:    rsp_in.mnemonic_code = rvdec_pkg::MN_ADDI;
               3'd1: begin
                  rsp_in.mnemonic_code = rvdec_pkg::MN_SLLI;
                  rsp_in.operand_value = {27'd0, word[24:20]};
               end
               3'd2:    rsp_in.mnemonic_code = rvdec_pkg::MN_SLTI;
               3'd3:    rsp_in.mnemonic_code = rvdec_pkg::MN_SLTIU;
               3'd4:    rsp_in.mnemonic_code = rvdec_pkg::MN_XORI;
               3'd5: begin
                  rsp_in.mnemonic_code = (f7 == rvdec_pkg::F7_ALT) ?
                                         rvdec_pkg::MN_SRAI : rvdec_pkg::MN_SRLI;
                  rsp_in.operand_value = {27'd0, word[24:20]};
               end
               3'd6:    rsp_in.mnemonic_code = rvdec_pkg::MN_ORI;
               default: rsp_in.mnemonic_code = rvdec_pkg::MN_ANDI;
            endcase
         end
         rvdec_pkg::OPC_OP: begin
            if (f7 == rvdec_pkg::F7_MEXT) begin
               case (f3)
                  3'd0:    rsp_in.mnemonic_code = rvdec_pkg::MN_MUL;
                  3'd1:    rsp_in.mnemonic_code = rvdec_pkg::MN_MULH;
                  3'd2:    rsp_in.mnemonic_code = rvdec_pkg::MN_MULHSU;
                  3'd3:    rsp_in.mnemonic_code = rvdec_pkg::MN_MULHU;
                  3'd4:    rsp_in.mnemonic_code = rvdec_pkg::MN_DIV;
                  3'd5:    rsp_in.mnemonic_code = rvdec_pkg::MN_DIVU;
                  3'd6:    rsp_in.mnemonic_code = rvdec_pkg::MN_REM;
                  default: rsp_in.mnemonic_code = rvdec_pkg::MN_REMU;
               endcase
            end else begin
               // Any funct7 other than the alternate code decodes as the base op
               case (f3)
                  3'd0:    rsp_in.mnemonic_code = (f7 == rvdec_pkg::F7_ALT) ?
                                                  rvdec_pkg::MN_SUB : rvdec_pkg::MN_ADD;
                  3'd1:    rsp_in.mnemonic_code = rvdec_pkg::MN_SLL;
                  3'd2:    rsp_in.mnemonic_code = rvdec_pkg::MN_SLT;
                  3'd3:    rsp_in.mnemonic_code = rvdec_pkg::MN_SLTU;
                  3'd4:    rsp_in.mnemonic_code = rvdec_pkg::MN_XOR;
                  3'd5:    rsp_in.mnemonic_code = (f7 == rvdec_pkg::F7_ALT) ?
                                                  rvdec_pkg::MN_SRA : rvdec_pkg::MN_SRL;
                  3'd6:    rsp_in.mnemonic_code = rvdec_pkg::MN_OR;
                  default: rsp_in.mnemonic_code = rvdec_pkg::MN_AND;
               endcase
            end
         end
         rvdec_pkg::OPC_SYSTEM: begin
            rsp_in.mnemonic_code = (word == rvdec_pkg::ECALL_WORD) ?
                                   rvdec_pkg::MN_ECALL : rvdec_pkg::MN_BAD_SYS;
         end
         default: begin
            rsp_in.mnemonic_code = rvdec_pkg::MN_BAD_OPC;
            rsp_in.operand_value = word;
         end
      endcase
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/rvdec_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the RV32IM instruction decoder, bound to the top level.
// Depends on rvdec_pkg and rv32im_instruction_decoder_unit.

module rvdec_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input rvdec_pkg::req_type req_payload,
   input logic               rsp_strobe,
   input rvdec_pkg::rsp_type rsp_payload
);

   // Every accepted transaction yields a result strobe
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("accepted transaction produced no result");

   // No result without an earlier accepted transaction
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##2 !rsp_strobe)
      else $error("result strobe without a matching transaction");

   // Register fields come straight from the accepted word
   a_reg_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         rsp_payload.dest_reg == $past(req_payload.instruction_word[11:7], 2) &&
         rsp_payload.src1_reg == $past(req_payload.instruction_word[19:15], 2) &&
         rsp_payload.src2_reg == $past(req_payload.instruction_word[24:20], 2))
      else $error("register fields do not match the accepted word");

   // Unknown opcode returns the raw word, so its rd bits line up with dest_reg
   a_raw_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.mnemonic_code == rvdec_pkg::MN_BAD_OPC) |->
         rsp_payload.operand_value[11:7] == rsp_payload.dest_reg &&
         rsp_payload.operand_value[19:15] == rsp_payload.src1_reg)
      else $error("unknown opcode operand is not the raw word");

endmodule

bind rv32im_instruction_decoder_unit rvdec_checker u_rvdec_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);
